FILE: hdl/md5_pkg.sv
package md5_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_PRIME,
        ST_ADD,
        ST_ROT,
        ST_FINAL,
        ST_EMIT
    } state_t;

    typedef logic [31:0] word_t;

    localparam word_t INIT_A = 32'h67452301;
    localparam word_t INIT_B = 32'hefcdab89;
    localparam word_t INIT_C = 32'h98badcfe;
    localparam word_t INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [1:0] LAST_WORD_IDX = 2'd3;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam word_t ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by round i
    function automatic logic [3:0] word_sel(input logic [5:0] i);
        logic [3:0] n;
        logic [3:0] g;
        begin
            n = i[3:0];
            case (i[5:4])
                2'd0:    g = n;
                2'd1:    g = 4'(n * 4'd5 + 4'd1);
                2'd2:    g = 4'(n * 4'd3 + 4'd5);
                default: g = 4'(n * 4'd7);
            endcase
            return g;
        end
    endfunction

    function automatic word_t round_fn(input logic [1:0] phase, input word_t b,
                                       input word_t c, input word_t d);
        word_t f;
        begin
            case (phase)
                2'd0:    f = (b & c) | (~b & d);
                2'd1:    f = (b & d) | (c & ~d);
                2'd2:    f = b ^ c ^ d;
                default: f = c ^ (b | ~d);
            endcase
            return f;
        end
    endfunction

endpackage

FILE: hdl/md5_in_if.sv
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

FILE: hdl/md5_out_if.sv
interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

FILE: hdl/md5_message_digest_core.sv
// md5 message digest core
// msg: one request per message byte (has_byte) with end_of_message on the
//   final request; a request with end_of_message and no byte closes the
//   message with the bytes taken so far (empty message if none).
// digest: four words, word_index 0 to 3, last_word on word 3; digest bytes
//   are the little-endian bytes of the words in index order.
// every 64th byte starts a compression (a load step, 64 rounds each of an
//   add step and a rotate step through the single round adder and rotator,
//   then one chaining add), during which msg is not ready.
// after the end request the core writes the padding and length bytes one at
//   a time through the block buffer port, with one or two compressions, then
//   presents the digest words.
// msg ready is low while padding, compressing or presenting the digest; a
//   stall on digest holds the current word until it is taken.
// reset loads the initial chaining words and clears byte position and bit
//   count; the block buffer holds no reset value and needs no clearing.
module md5_message_digest_core
    import md5_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    md5_in_if.sink    msg,
    md5_out_if.source digest
);

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bitlen_reg, bitlen_next;
    word_t       h_reg [4];
    word_t       h_next [4];
    logic [1:0]  widx_reg, widx_next;
    logic [5:0]  round_reg, round_next;
    word_t       a_reg, a_next;
    word_t       b_reg, b_next;
    word_t       c_reg, c_next;
    word_t       d_reg, d_next;
    word_t       t_reg, t_next;
    word_t       word_rd_reg;

    word_t       buf_mem [16];
    logic        wr_en;
    logic [7:0]  wr_data;
    logic [3:0]  rd_addr;

    logic        in_acc;
    logic        out_acc;
    logic [63:0] rot_wide;

    assign in_acc  = msg.valid && msg.ready;
    assign out_acc = digest.valid && digest.ready;
    assign rot_wide = {t_reg, t_reg} << ROT_AMT[{round_reg[5:4], round_reg[1:0]}];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (msg.has_byte && pos_reg == LAST_POS)
                        state_next = ST_PRIME;
                    else if (msg.end_of_message)
                        state_next = ST_PAD80;
                end
            end
            ST_PAD80:
                state_next = (pos_reg == LAST_POS) ? ST_PRIME : ST_PADZ;
            ST_PADZ:
            begin
                if (pos_reg == LEN_POS)
                    state_next = ST_PADLEN;
                else if (pos_reg == LAST_POS)
                    state_next = ST_PRIME;
            end
            ST_PADLEN:
            begin
                if (pos_reg == LAST_POS)
                    state_next = ST_PRIME;
            end
            ST_PRIME: state_next = ST_ADD;
            ST_ADD:   state_next = ST_ROT;
            ST_ROT:   state_next = (round_reg == LAST_ROUND) ? ST_FINAL : ST_ADD;
            ST_FINAL: state_next = ret_reg;
            ST_EMIT:
            begin
                if (out_acc && widx_reg == LAST_WORD_IDX)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        msg.ready          = (state_reg == ST_IDLE);
        digest.valid       = (state_reg == ST_EMIT);
        digest.digest_word = h_reg[widx_reg];
        digest.word_index  = widx_reg;
        digest.last_word   = (widx_reg == LAST_WORD_IDX);
        wr_en   = 1'b0;
        wr_data = 8'd0;
        rd_addr = word_sel(round_reg);
        case (state_reg)
            ST_IDLE:
            begin
                wr_en   = in_acc && msg.has_byte;
                wr_data = msg.data_byte;
            end
            ST_PAD80:
            begin
                wr_en   = 1'b1;
                wr_data = PAD_BYTE;
            end
            ST_PADZ:
                wr_en = (pos_reg != LEN_POS);
            ST_PADLEN:
            begin
                wr_en   = 1'b1;
                wr_data = bitlen_reg[{pos_reg[2:0], 3'b000} +: 8];
            end
            ST_PRIME:
                rd_addr = word_sel(6'd0);
            ST_ROT:
                rd_addr = word_sel(round_reg + 6'd1);
            default:
                wr_en = 1'b0;
        endcase
    end

    // datapath and counters
    always_comb
    begin
        ret_next    = ret_reg;
        pos_next    = pos_reg;
        bitlen_next = bitlen_reg;
        h_next      = h_reg;
        widx_next   = widx_reg;
        round_next  = round_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        t_next      = t_reg;
        if (wr_en)
            pos_next = pos_reg + 6'd1;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && msg.has_byte)
                    bitlen_next = bitlen_reg + BITS_PER_BYTE;
                ret_next = msg.end_of_message ? ST_PAD80 : ST_IDLE;
            end
            ST_PAD80:  ret_next = ST_PADZ;
            ST_PADZ:   ret_next = ST_PADZ;
            ST_PADLEN: ret_next = ST_EMIT;
            ST_PRIME:
            begin
                a_next     = h_reg[0];
                b_next     = h_reg[1];
                c_next     = h_reg[2];
                d_next     = h_reg[3];
                round_next = 6'd0;
            end
            ST_ADD:
                t_next = a_reg + round_fn(round_reg[5:4], b_reg, c_reg, d_reg)
                       + word_rd_reg + ROUND_K[round_reg];
            ST_ROT:
            begin
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = b_reg + rot_wide[63:32];
                round_next = round_reg + 6'd1;
            end
            ST_FINAL:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                widx_next = 2'd0;
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    widx_next = widx_reg + 2'd1;
                    if (widx_reg == LAST_WORD_IDX)
                    begin
                        h_next[0]   = INIT_A;
                        h_next[1]   = INIT_B;
                        h_next[2]   = INIT_C;
                        h_next[3]   = INIT_D;
                        pos_next    = 6'd0;
                        bitlen_next = 64'd0;
                    end
                end
            end
            default:
                ret_next = ret_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            pos_reg    <= 6'd0;
            bitlen_reg <= 64'd0;
            h_reg[0]   <= INIT_A;
            h_reg[1]   <= INIT_B;
            h_reg[2]   <= INIT_C;
            h_reg[3]   <= INIT_D;
            widx_reg   <= 2'd0;
            round_reg  <= 6'd0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            pos_reg    <= pos_next;
            bitlen_reg <= bitlen_next;
            h_reg      <= h_next;
            widx_reg   <= widx_next;
            round_reg  <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        t_reg <= t_next;
    end

    // block buffer, little-endian words
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[pos_reg[5:2]][{pos_reg[1:0], 3'b000} +: 8] <= wr_data;
        word_rd_reg <= buf_mem[rd_addr];
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        msg.ready |-> !digest.valid)
        else $error("request taken while digest pending");

    a_emit_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && !digest.last_word) |=> digest.valid)
        else $error("digest ended before last word");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT && round_reg == LAST_ROUND) |=> state_reg == ST_FINAL)
        else $error("compression did not finish after last round");

    a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> pos_reg == 6'd0)
        else $error("padding left block misaligned");

endmodule
